// ===== design/rsz_pkg.sv =====
// ----------------------------------------------------------------------------
// Rescaler package
// Shared widths, register map, reset values and pipeline types.
// ----------------------------------------------------------------------------
package rsz_pkg;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int POS_W   = 8;
   localparam int OUT_W   = 12;
   localparam int SIZE_W  = 9;
   localparam int SCALE_W = 24;
   localparam int SRC_W   = 24;
   localparam int DST_W   = OUT_W + FRAC_BITS;
   localparam int DIFF_W  = DST_W + 1;
   localparam int PROD_W  = DIFF_W + SCALE_W;
   localparam int MAP_W   = PROD_W - FRAC_BITS + 1;
   localparam int IDX_W   = MAP_W - FRAC_BITS + 1;
   localparam int WGT_W   = FRAC_BITS + 1;
   localparam int WPROD_W = 2 * WGT_W;
   localparam int TERM_W  = WPROD_W + SAMPLE_BITS + 1;
   localparam int ACC_W   = TERM_W + 2;
   localparam int QUOT_W  = ACC_W - 2 * FRAC_BITS + 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_INTERP_MODE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INV_SCALE      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SRC_ROWS       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SRC_COLS       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SRC_CENTER_ROW = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SRC_CENTER_COL = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DST_CENTER_ROW = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_DST_CENTER_COL = 3'd7;

   localparam logic               MODE_NEAREST    = 1'b0;
   localparam logic               OP_LOAD         = 1'b0;
   localparam logic               RST_INTERP_MODE = 1'b1;
   localparam logic [SCALE_W-1:0] RST_INV_SCALE   = 24'd65536;
   localparam logic [SIZE_W-1:0]  RST_SRC_SIZE    = 9'd256;
   localparam logic [SRC_W-1:0]   RST_SRC_CENTER  = 24'd8355840;
   localparam logic [DST_W-1:0]   RST_DST_CENTER  = 28'd8355840;

   typedef struct packed {
      logic [POS_W-1:0]       row;
      logic [POS_W-1:0]       col;
      logic [SAMPLE_BITS-1:0] value;
   } load_type;

   typedef struct packed {
      logic en;
      logic wr_en;
   } store_ctrl_type;

endpackage

// ===== design/rsz_coord_map.sv =====
// ----------------------------------------------------------------------------
// Coordinate mapper
// Three stages: centre offset, scale product, floor shift plus source centre.
// ----------------------------------------------------------------------------
module rsz_coord_map (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [rsz_pkg::OUT_W-1:0]              out_idx,
   input  logic [rsz_pkg::DST_W-1:0]              dst_center,
   input  logic [rsz_pkg::SRC_W-1:0]              src_center,
   input  logic [rsz_pkg::SCALE_W-1:0]            inv_scale,
   output logic signed [rsz_pkg::MAP_W-1:0]       mapped
);

   logic signed [rsz_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [rsz_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [rsz_pkg::MAP_W-1:0]  map_ff, map_in;

   assign diff_in = $signed({1'b0, out_idx, {rsz_pkg::FRAC_BITS{1'b0}}})
                  - $signed({1'b0, dst_center});
   assign prod_in = rsz_pkg::PROD_W'(diff_ff)
                  * rsz_pkg::PROD_W'($signed({1'b0, inv_scale}));
   assign map_in  = rsz_pkg::MAP_W'($signed(prod_ff[rsz_pkg::PROD_W-1:rsz_pkg::FRAC_BITS]))
                  + $signed(rsz_pkg::MAP_W'({1'b0, src_center}));

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         map_ff  <= map_in;
      end
   end

   assign mapped = map_ff;

endmodule

// ===== design/rsz_tap_store.sv =====
// ----------------------------------------------------------------------------
// Banked source image store, four banks by row and column parity.
// One write and four tap reads a cycle while ctrl.en is high.
// ----------------------------------------------------------------------------
module rsz_tap_store #(
   parameter int MAX_ROWS = rsz_pkg::MAX_ROWS,
   parameter int MAX_COLS = rsz_pkg::MAX_COLS
) (
   input  logic                                    clock,
   input  rsz_pkg::store_ctrl_type                 ctrl,
   input  rsz_pkg::load_type                       load,
   input  logic signed [rsz_pkg::IDX_W-1:0]        r0,
   input  logic signed [rsz_pkg::IDX_W-1:0]        c0,
   input  logic [rsz_pkg::SIZE_W-1:0]              rows_eff,
   input  logic [rsz_pkg::SIZE_W-1:0]              cols_eff,
   output logic signed [rsz_pkg::SAMPLE_BITS-1:0]  tap [2][2]
);

   localparam int BR    = (MAX_ROWS + 1) / 2;
   localparam int BC    = (MAX_COLS + 1) / 2;
   localparam int DEPTH = BR * BC;
   localparam int BRW   = (BR > 1) ? $clog2(BR) : 1;
   localparam int BCW   = (BC > 1) ? $clog2(BC) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [AW-1:0]                  wr_addr;
   logic                           wr_ok;
   logic [AW-1:0]                  rd_addr [4];
   logic signed [rsz_pkg::IDX_W-1:0] r1, c1;
   logic [BRW-1:0]                 row_half [2];
   logic [BCW-1:0]                 col_half [2];
   logic                           ok_in [2][2];
   logic                           ok_ff [2][2];
   logic                           rpar_ff, cpar_ff;
   logic signed [rsz_pkg::IDX_W-1:0] rows_s, cols_s;
   logic [rsz_pkg::SAMPLE_BITS-1:0] rd_ff [4];

   assign rows_s = $signed(rsz_pkg::IDX_W'(rows_eff));
   assign cols_s = $signed(rsz_pkg::IDX_W'(cols_eff));
   assign r1     = r0 + rsz_pkg::IDX_W'(1);
   assign c1     = c0 + rsz_pkg::IDX_W'(1);

   assign wr_ok   = (32'(load.row) < MAX_ROWS) && (32'(load.col) < MAX_COLS);
   assign wr_addr = AW'(32'(load.row >> 1) * BC + 32'(load.col >> 1));

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         row_half[p] = (r0[0] == p[0]) ? r0[BRW:1] : r1[BRW:1];
         col_half[p] = (c0[0] == p[0]) ? c0[BCW:1] : c1[BCW:1];
      end
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = AW'(32'(row_half[b/2]) * BC + 32'(col_half[b%2]));
      end
      ok_in[0][0] = !r0[rsz_pkg::IDX_W-1] && (r0 < rows_s)
                 && !c0[rsz_pkg::IDX_W-1] && (c0 < cols_s);
      ok_in[0][1] = !r0[rsz_pkg::IDX_W-1] && (r0 < rows_s)
                 && !c1[rsz_pkg::IDX_W-1] && (c1 < cols_s);
      ok_in[1][0] = !r1[rsz_pkg::IDX_W-1] && (r1 < rows_s)
                 && !c0[rsz_pkg::IDX_W-1] && (c0 < cols_s);
      ok_in[1][1] = !r1[rsz_pkg::IDX_W-1] && (r1 < rows_s)
                 && !c1[rsz_pkg::IDX_W-1] && (c1 < cols_s);
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [rsz_pkg::SAMPLE_BITS-1:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (ctrl.en) begin
            if (ctrl.wr_en && wr_ok && load.row[0] == b[1] && load.col[0] == b[0]) begin
               mem[wr_addr] <= load.value;
            end
            rd_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         ok_ff   <= ok_in;
         rpar_ff <= r0[0];
         cpar_ff <= c0[0];
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            tap[i][j] = ok_ff[i][j]
                      ? $signed(rd_ff[{rpar_ff ^ i[0], cpar_ff ^ j[0]}])
                      : '0;
         end
      end
   end

endmodule

// ===== design/rsz_blend.sv =====
// ----------------------------------------------------------------------------
// Bilinear blend
// Weights, tap products, four-term sum, then round and saturate.
// ----------------------------------------------------------------------------
module rsz_blend (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [rsz_pkg::SAMPLE_BITS-1:0]  tap [2][2],
   input  logic [rsz_pkg::FRAC_BITS-1:0]           frac_row,
   input  logic [rsz_pkg::FRAC_BITS-1:0]           frac_col,
   output logic signed [rsz_pkg::SAMPLE_BITS-1:0]  pixel
);

   localparam logic [rsz_pkg::WGT_W-1:0] ONE = rsz_pkg::WGT_W'(1) << rsz_pkg::FRAC_BITS;
   localparam logic [rsz_pkg::ACC_W-1:0] HALF =
      rsz_pkg::ACC_W'(1) << (2 * rsz_pkg::FRAC_BITS - 1);
   localparam logic [rsz_pkg::QUOT_W-1:0] MAXQ =
      rsz_pkg::QUOT_W'((64'd1 << (rsz_pkg::SAMPLE_BITS - 1)) - 1);
   localparam logic [rsz_pkg::QUOT_W-1:0] MINQ =
      rsz_pkg::QUOT_W'(64'd1 << (rsz_pkg::SAMPLE_BITS - 1));

   logic [rsz_pkg::WGT_W-1:0]         wr [2], wc [2];
   logic [rsz_pkg::WPROD_W-1:0]       w_ff [2][2];
   logic signed [rsz_pkg::SAMPLE_BITS-1:0] t_ff [2][2];
   logic signed [rsz_pkg::TERM_W-1:0] term_ff [2][2];
   logic signed [rsz_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [rsz_pkg::ACC_W-1:0]         mag, rnd;
   logic [rsz_pkg::QUOT_W-1:0]        quot;
   logic signed [rsz_pkg::SAMPLE_BITS-1:0] res_ff, res_in;

   assign wr[0] = ONE - rsz_pkg::WGT_W'(frac_row);
   assign wr[1] = rsz_pkg::WGT_W'(frac_row);
   assign wc[0] = ONE - rsz_pkg::WGT_W'(frac_col);
   assign wc[1] = rsz_pkg::WGT_W'(frac_col);

   assign acc_in = rsz_pkg::ACC_W'(term_ff[0][0]) + rsz_pkg::ACC_W'(term_ff[0][1])
                 + rsz_pkg::ACC_W'(term_ff[1][0]) + rsz_pkg::ACC_W'(term_ff[1][1]);

   assign mag  = acc_ff[rsz_pkg::ACC_W-1] ? rsz_pkg::ACC_W'(-acc_ff)
                                          : rsz_pkg::ACC_W'(acc_ff);
   assign rnd  = mag + HALF;
   assign quot = rsz_pkg::QUOT_W'(rnd >> (2 * rsz_pkg::FRAC_BITS));

   always_comb begin
      if (!acc_ff[rsz_pkg::ACC_W-1]) begin
         res_in = (quot > MAXQ) ? $signed(rsz_pkg::SAMPLE_BITS'(MAXQ))
                                : $signed(rsz_pkg::SAMPLE_BITS'(quot));
      end else begin
         res_in = (quot > MINQ) ? $signed(rsz_pkg::SAMPLE_BITS'(MINQ))
                                : $signed(rsz_pkg::SAMPLE_BITS'(-quot));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
               w_ff[i][j]    <= rsz_pkg::WPROD_W'(wr[i]) * rsz_pkg::WPROD_W'(wc[j]);
               t_ff[i][j]    <= tap[i][j];
               term_ff[i][j] <= rsz_pkg::TERM_W'($signed({1'b0, w_ff[i][j]}))
                              * rsz_pkg::TERM_W'(t_ff[i][j]);
            end
         end
         acc_ff <= acc_in;
         res_ff <= res_in;
      end
   end

   assign pixel = res_ff;

endmodule

// ===== design/bilinear_image_rescaler_core.sv =====
// ----------------------------------------------------------------------------
// Bilinear image rescaler core
// Centred 2D rescaler with a banked source store, nearest or bilinear.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            content
//  req_     in         req_valid/req_stall  load pixel or request output pixel
//  rsp_     out        rsp_valid/rsp_stall  one pixel per request
//  csr_     in/out     APB-style            eight mode/scale/size/centre regs
//
//  One transaction per cycle unless stalled; a request yields its pixel
//  via the nine-stage pipeline (three mapping, tap, store read, four blend).
//  Loads write the store in stage five and leave no result.
//  A stalled result freezes the whole pipeline; reset clears valids, resets regs.
// ----------------------------------------------------------------------------
module bilinear_image_rescaler_core #(
   parameter int MAX_ROWS = rsz_pkg::MAX_ROWS,
   parameter int MAX_COLS = rsz_pkg::MAX_COLS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [rsz_pkg::POS_W-1:0]              req_sample_row,
   input  logic [rsz_pkg::POS_W-1:0]              req_sample_col,
   input  logic signed [rsz_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic [rsz_pkg::OUT_W-1:0]              req_out_row,
   input  logic [rsz_pkg::OUT_W-1:0]              req_out_col,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rsz_pkg::SAMPLE_BITS-1:0] rsp_pixel_value,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rsz_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [rsz_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [rsz_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   logic                          mode_ff;
   logic [rsz_pkg::SCALE_W-1:0]   scale_ff;
   logic [rsz_pkg::SIZE_W-1:0]    rows_ff, cols_ff;
   logic [rsz_pkg::SRC_W-1:0]     src_r_ff, src_c_ff;
   logic [rsz_pkg::DST_W-1:0]     dst_r_ff, dst_c_ff;
   logic [rsz_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          csr_wr;

   logic                          advance;
   logic [9:1]                    v_ff;
   logic [4:1]                    op_ff;
   rsz_pkg::load_type             load_ff [4:1];
   rsz_pkg::load_type             load_in;

   logic signed [rsz_pkg::MAP_W-1:0] map_r, map_c;
   logic signed [rsz_pkg::IDX_W-1:0] r0_ff, c0_ff, r0_in, c0_in;
   logic [rsz_pkg::FRAC_BITS-1:0]    fr4_ff, fc4_ff, fr4_in, fc4_in;
   logic [rsz_pkg::FRAC_BITS-1:0]    fr5_ff, fc5_ff;
   logic [rsz_pkg::SIZE_W-1:0]       rows_eff, cols_eff;
   logic signed [rsz_pkg::SAMPLE_BITS-1:0] tap [2][2];
   logic signed [rsz_pkg::SAMPLE_BITS-1:0] tap_sel [2][2];
   rsz_pkg::store_ctrl_type          store_ctrl;

   // register port
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rsz_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rsz_pkg::RST_INTERP_MODE;
         scale_ff <= rsz_pkg::RST_INV_SCALE;
         rows_ff  <= rsz_pkg::RST_SRC_SIZE;
         cols_ff  <= rsz_pkg::RST_SRC_SIZE;
         src_r_ff <= rsz_pkg::RST_SRC_CENTER;
         src_c_ff <= rsz_pkg::RST_SRC_CENTER;
         dst_r_ff <= rsz_pkg::RST_DST_CENTER;
         dst_c_ff <= rsz_pkg::RST_DST_CENTER;
      end else if (csr_wr) begin
         case (reg_idx)
            rsz_pkg::REG_INTERP_MODE:    mode_ff  <= csr_pwdata[0];
            rsz_pkg::REG_INV_SCALE:      scale_ff <= csr_pwdata[rsz_pkg::SCALE_W-1:0];
            rsz_pkg::REG_SRC_ROWS:       rows_ff  <= csr_pwdata[rsz_pkg::SIZE_W-1:0];
            rsz_pkg::REG_SRC_COLS:       cols_ff  <= csr_pwdata[rsz_pkg::SIZE_W-1:0];
            rsz_pkg::REG_SRC_CENTER_ROW: src_r_ff <= csr_pwdata[rsz_pkg::SRC_W-1:0];
            rsz_pkg::REG_SRC_CENTER_COL: src_c_ff <= csr_pwdata[rsz_pkg::SRC_W-1:0];
            rsz_pkg::REG_DST_CENTER_ROW: dst_r_ff <= csr_pwdata[rsz_pkg::DST_W-1:0];
            rsz_pkg::REG_DST_CENTER_COL: dst_c_ff <= csr_pwdata[rsz_pkg::DST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rsz_pkg::REG_INTERP_MODE:    csr_prdata = rsz_pkg::CSR_DATA_W'(mode_ff);
         rsz_pkg::REG_INV_SCALE:      csr_prdata = rsz_pkg::CSR_DATA_W'(scale_ff);
         rsz_pkg::REG_SRC_ROWS:       csr_prdata = rsz_pkg::CSR_DATA_W'(rows_ff);
         rsz_pkg::REG_SRC_COLS:       csr_prdata = rsz_pkg::CSR_DATA_W'(cols_ff);
         rsz_pkg::REG_SRC_CENTER_ROW: csr_prdata = rsz_pkg::CSR_DATA_W'(src_r_ff);
         rsz_pkg::REG_SRC_CENTER_COL: csr_prdata = rsz_pkg::CSR_DATA_W'(src_c_ff);
         rsz_pkg::REG_DST_CENTER_ROW: csr_prdata = rsz_pkg::CSR_DATA_W'(dst_r_ff);
         rsz_pkg::REG_DST_CENTER_COL: csr_prdata = rsz_pkg::CSR_DATA_W'(dst_c_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // pipeline control
   assign advance   = !(v_ff[9] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = v_ff[9];

   assign load_in.row   = req_sample_row;
   assign load_in.col   = req_sample_col;
   assign load_in.value = req_sample_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff[1] <= req_valid;
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3];
         v_ff[5] <= v_ff[4] && (op_ff[4] != rsz_pkg::OP_LOAD);
         v_ff[9:6] <= v_ff[8:5];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[1]   <= req_opcode;
         load_ff[1] <= load_in;
         for (int s = 2; s <= 4; s++) begin
            op_ff[s]   <= op_ff[s-1];
            load_ff[s] <= load_ff[s-1];
         end
         r0_ff  <= r0_in;
         c0_ff  <= c0_in;
         fr4_ff <= fr4_in;
         fc4_ff <= fc4_in;
         fr5_ff <= fr4_ff;
         fc5_ff <= fc4_ff;
      end
   end

   // coordinate mapping, stages one to three
   rsz_coord_map u_map_row (
      .clock      (clock),
      .en         (advance),
      .out_idx    (req_out_row),
      .dst_center (dst_r_ff),
      .src_center (src_r_ff),
      .inv_scale  (scale_ff),
      .mapped     (map_r)
   );

   rsz_coord_map u_map_col (
      .clock      (clock),
      .en         (advance),
      .out_idx    (req_out_col),
      .dst_center (dst_c_ff),
      .src_center (src_c_ff),
      .inv_scale  (scale_ff),
      .mapped     (map_c)
   );

   // tap position, stage four
   function automatic logic signed [rsz_pkg::IDX_W-1:0] round_idx(
      input logic signed [rsz_pkg::MAP_W-1:0] m
   );
      logic [rsz_pkg::MAP_W-1:0]          mag;
      logic [rsz_pkg::MAP_W-1:0]          sum;
      logic [rsz_pkg::IDX_W-1:0]          q;
      mag = m[rsz_pkg::MAP_W-1] ? rsz_pkg::MAP_W'(-m) : rsz_pkg::MAP_W'(m);
      sum = mag + (rsz_pkg::MAP_W'(1) << (rsz_pkg::FRAC_BITS - 1));
      q   = rsz_pkg::IDX_W'(sum >> rsz_pkg::FRAC_BITS);
      return m[rsz_pkg::MAP_W-1] ? $signed(-q) : $signed(q);
   endfunction

   always_comb begin
      if (mode_ff == rsz_pkg::MODE_NEAREST) begin
         r0_in  = round_idx(map_r);
         c0_in  = round_idx(map_c);
         fr4_in = '0;
         fc4_in = '0;
      end else begin
         r0_in  = rsz_pkg::IDX_W'($signed(map_r[rsz_pkg::MAP_W-1:rsz_pkg::FRAC_BITS]));
         c0_in  = rsz_pkg::IDX_W'($signed(map_c[rsz_pkg::MAP_W-1:rsz_pkg::FRAC_BITS]));
         fr4_in = map_r[rsz_pkg::FRAC_BITS-1:0];
         fc4_in = map_c[rsz_pkg::FRAC_BITS-1:0];
      end
   end

   assign rows_eff = (32'(rows_ff) > MAX_ROWS) ? rsz_pkg::SIZE_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (32'(cols_ff) > MAX_COLS) ? rsz_pkg::SIZE_W'(MAX_COLS) : cols_ff;

   // store write and tap read, stage five
   assign store_ctrl.en    = advance;
   assign store_ctrl.wr_en = v_ff[4] && (op_ff[4] == rsz_pkg::OP_LOAD);

   rsz_tap_store #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_store (
      .clock    (clock),
      .ctrl     (store_ctrl),
      .load     (load_ff[4]),
      .r0       (r0_ff),
      .c0       (c0_ff),
      .rows_eff (rows_eff),
      .cols_eff (cols_eff),
      .tap      (tap)
   );

   // drop the three unused taps in nearest mode
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            tap_sel[i][j] = (mode_ff == rsz_pkg::MODE_NEAREST && (i != 0 || j != 0))
                          ? '0 : tap[i][j];
         end
      end
   end

   // blend, stages six to nine
   rsz_blend u_blend (
      .clock    (clock),
      .en       (advance),
      .tap      (tap_sel),
      .frac_row (fr5_ff),
      .frac_col (fc5_ff),
      .pixel    (rsp_pixel_value)
   );

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (v_ff[9] && rsp_stall) |=> (v_ff == $past(v_ff)))
      else $error("pipeline moved while result stalled");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (advance && v_ff[4] && op_ff[4] == rsz_pkg::OP_LOAD) |=> !v_ff[5])
      else $error("load transaction reached blend stages");

   a_nearest_frac: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && mode_ff == rsz_pkg::MODE_NEAREST && $stable(mode_ff))
      |-> (fr4_ff == '0 && fc4_ff == '0))
      else $error("nearest transaction carries a fraction");

endmodule

// ===== tb/sv/bilinear_image_rescaler_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bilinear image rescaler core testbench
// Loads source pixels, requests nearest and bilinear output pixels under
// several register settings, and checks every pixel against a given value
// or an in-bench fixed-point predictor. Channels idle and stall at random.
// ----------------------------------------------------------------------------
module bilinear_image_rescaler_core_tb;

   localparam logic OP_REQUEST    = 1'b1;
   localparam logic MODE_BILINEAR = 1'b1;
   localparam int   CYCLE_LIMIT   = 400000;
   localparam int   DRAIN_CYCLES  = 14;
   localparam int   NUM_PHASES    = 12;

   typedef struct {
      logic        op;
      logic [7:0]  srow;
      logic [7:0]  scol;
      logic [15:0] val;
      logic [11:0] orow;
      logic [11:0] ocol;
      bit          typed;
      logic [15:0] pix;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic req_opcode = rsz_pkg::OP_LOAD;
   logic [7:0] req_sample_row = '0, req_sample_col = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [11:0] req_out_row = '0, req_out_col = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic signed [15:0] rsp_pixel_value;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [rsz_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rsz_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rsz_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bilinear_image_rescaler_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        cfg_mode;
   logic [23:0] cfg_inv_scale, cfg_src_crow, cfg_src_ccol;
   logic [8:0]  cfg_rows, cfg_cols;
   logic [27:0] cfg_dst_crow, cfg_dst_ccol;
   int          image_mem [0:65535];
   bit          image_written [0:65535];

   logic [15:0] pixel_fifo[$];
   int          errors = 0, n_req = 0, n_load = 0, n_rsp = 0;
   longint      cycle_count = 0;
   bit          idle_on = 1'b1;

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint rnd_shift(longint v, int s);
      longint half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic longint map_axis(logic [11:0] o, logic [27:0] dc, logic [23:0] sc);
      longint d = (longint'(o) << 16) - longint'(dc);
      return ((d * longint'(cfg_inv_scale)) >>> 16) + longint'(sc);
   endfunction

   function automatic bit in_image(longint r, longint c);
      longint rows = cfg_rows > 256 ? 256 : cfg_rows;
      longint cols = cfg_cols > 256 ? 256 : cfg_cols;
      return r >= 0 && r < rows && c >= 0 && c < cols;
   endfunction

   function automatic longint pixel_at(longint r, longint c);
      return in_image(r, c) ? longint'(image_mem[r * 256 + c]) : 0;
   endfunction

   function automatic bit readable(longint r, longint c);
      return !in_image(r, c) || image_written[r * 256 + c];
   endfunction

   function automatic bit taps_written(logic [11:0] orow, logic [11:0] ocol);
      longint mr = map_axis(orow, cfg_dst_crow, cfg_src_crow);
      longint mc = map_axis(ocol, cfg_dst_ccol, cfg_src_ccol);
      longint r0 = mr >>> 16, c0 = mc >>> 16;
      if (cfg_mode == rsz_pkg::MODE_NEAREST)
         return readable(rnd_shift(mr, 16), rnd_shift(mc, 16));
      return readable(r0, c0) && readable(r0, c0 + 1) &&
             readable(r0 + 1, c0) && readable(r0 + 1, c0 + 1);
   endfunction

   function automatic logic [15:0] predict_pixel(logic [11:0] orow, logic [11:0] ocol);
      longint mr = map_axis(orow, cfg_dst_crow, cfg_src_crow);
      longint mc = map_axis(ocol, cfg_dst_ccol, cfg_src_ccol);
      longint one = longint'(1) << 16;
      longint r0 = mr >>> 16, c0 = mc >>> 16;
      longint fr = mr - (r0 << 16), fc = mc - (c0 << 16);
      longint res, acc;
      if (cfg_mode == rsz_pkg::MODE_NEAREST) begin
         res = pixel_at(rnd_shift(mr, 16), rnd_shift(mc, 16));
      end else begin
         acc = (one - fr) * (one - fc) * pixel_at(r0, c0)
             + (one - fr) * fc * pixel_at(r0, c0 + 1)
             + fr * (one - fc) * pixel_at(r0 + 1, c0)
             + fr * fc * pixel_at(r0 + 1, c0 + 1);
         res = rnd_shift(acc, 32);
      end
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= rsz_pkg::CSR_ADDR_W'(idx) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         rsz_pkg::REG_INTERP_MODE:    cfg_mode      = val[0];
         rsz_pkg::REG_INV_SCALE:      cfg_inv_scale = val[23:0];
         rsz_pkg::REG_SRC_ROWS:       cfg_rows      = val[8:0];
         rsz_pkg::REG_SRC_COLS:       cfg_cols      = val[8:0];
         rsz_pkg::REG_SRC_CENTER_ROW: cfg_src_crow  = val[23:0];
         rsz_pkg::REG_SRC_CENTER_COL: cfg_src_ccol  = val[23:0];
         rsz_pkg::REG_DST_CENTER_ROW: cfg_dst_crow  = val[27:0];
         rsz_pkg::REG_DST_CENTER_COL: cfg_dst_ccol  = val[27:0];
         default: ;
      endcase
   endtask

   // hold until the pipeline is empty
   task automatic wait_drained();
      while (pixel_fifo.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_transaction(stim_row_type s);
      while (idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode <= s.op; req_sample_row <= s.srow; req_sample_col <= s.scol;
      req_sample_value <= s.val; req_out_row <= s.orow; req_out_col <= s.ocol;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (s.op == rsz_pkg::OP_LOAD) begin
         image_mem[{s.srow, s.scol}] = int'(signed'(s.val));
         image_written[{s.srow, s.scol}] = 1'b1;
         n_load++;
      end else begin
         pixel_fifo.push_back(s.typed ? s.pix : predict_pixel(s.orow, s.ocol));
         n_req++;
      end
      @(negedge clock);
   endtask

   function automatic stim_row_type load_item(logic [7:0] r, logic [7:0] c, logic [15:0] v);
      stim_row_type s;
      s.op = rsz_pkg::OP_LOAD; s.srow = r; s.scol = c; s.val = v;
      s.orow = 12'($urandom); s.ocol = 12'($urandom); s.typed = 1'b0; s.pix = '0;
      return s;
   endfunction

   function automatic stim_row_type req_item(logic [11:0] r, logic [11:0] c);
      stim_row_type s;
      s.op = OP_REQUEST; s.srow = 8'($urandom); s.scol = 8'($urandom);
      s.val = 16'($urandom); s.orow = r; s.ocol = c; s.typed = 1'b0; s.pix = '0;
      return s;
   endfunction

   function automatic logic [11:0] near_axis(logic [27:0] dc);
      int v = int'(dc >> 16) + $urandom_range(12) - 6;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   always @(negedge clock) rsp_stall <= idle_on && $urandom_range(99) < 13;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (pixel_fifo.size() == 0) report($sformatf("unexpected pixel %0d", rsp_pixel_value));
         else begin
            logic [15:0] want;
            want = pixel_fifo.pop_front();
            if (rsp_pixel_value !== want)
               report($sformatf("pixel_value got %0d want %0d",
                                rsp_pixel_value, signed'(want)));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      stim_row_type dir_table[$];
      stim_row_type s;
      logic [23:0] inv;
      logic [8:0]  rows, cols;
      logic [23:0] scr, scc;
      logic [27:0] dcr, dcc;
      int          h, w, tries;

      cfg_mode = rsz_pkg::RST_INTERP_MODE; cfg_inv_scale = rsz_pkg::RST_INV_SCALE;
      cfg_rows = rsz_pkg::RST_SRC_SIZE; cfg_cols = rsz_pkg::RST_SRC_SIZE;
      cfg_src_crow = rsz_pkg::RST_SRC_CENTER; cfg_src_ccol = rsz_pkg::RST_SRC_CENTER;
      cfg_dst_crow = rsz_pkg::RST_DST_CENTER; cfg_dst_ccol = rsz_pkg::RST_DST_CENTER;
      foreach (image_mem[i]) begin image_mem[i] = 0; image_written[i] = 1'b0; end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset settings map each output pixel onto itself
      dir_table.push_back(load_item(8'd0, 8'd0, 16'h7FFF));
      dir_table.push_back(load_item(8'd0, 8'd1, 16'h8000));
      dir_table.push_back(load_item(8'd1, 8'd0, 16'h0000));
      dir_table.push_back(load_item(8'd1, 8'd1, 16'hFFFF));
      dir_table.push_back(load_item(8'd0, 8'd2, 16'h0101));
      dir_table.push_back(load_item(8'd1, 8'd2, 16'h0202));
      dir_table.push_back(load_item(8'd2, 8'd0, 16'h0303));
      dir_table.push_back(load_item(8'd2, 8'd1, 16'h0404));
      dir_table.push_back(load_item(8'd2, 8'd2, 16'h0505));
      dir_table.push_back(load_item(8'd255, 8'd255, 16'hFFFF));
      dir_table.push_back(load_item(8'd254, 8'd254, 16'h5555));
      dir_table.push_back(load_item(8'd254, 8'd255, 16'hAAAA));
      dir_table.push_back(load_item(8'd255, 8'd254, 16'h1234));
      s = req_item(12'd0, 12'd0); s.typed = 1'b1; s.pix = 16'h7FFF; dir_table.push_back(s);
      s = req_item(12'd0, 12'd1); s.typed = 1'b1; s.pix = 16'h8000; dir_table.push_back(s);
      s = req_item(12'd1, 12'd1); s.typed = 1'b1; s.pix = 16'hFFFF; dir_table.push_back(s);
      s = req_item(12'd255, 12'd255); s.typed = 1'b1; s.pix = 16'hFFFF; dir_table.push_back(s);
      s = req_item(12'd4095, 12'd4095); s.typed = 1'b1; s.pix = 16'h0000; dir_table.push_back(s);
      s = req_item(12'd4095, 12'd0); s.typed = 1'b1; s.pix = 16'h0000; dir_table.push_back(s);
      dir_table.push_back(req_item(12'd254, 12'd254));
      dir_table.push_back(load_item(8'd0, 8'd0, 16'h8000));
      dir_table.push_back(req_item(12'd0, 12'd0));
      foreach (dir_table[i]) send_transaction(dir_table[i]);
      req_valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         idle_on = (p != 6);
         h = $urandom_range(2, 10);
         w = $urandom_range(2, 10);
         inv  = ($urandom_range(1)) ? 24'd65536 : 24'($urandom_range(16384, 200000));
         rows = 9'(h); cols = 9'(w);
         scr  = 24'($urandom_range(0, h << 16));
         scc  = 24'($urandom_range(0, w << 16));
         dcr  = 28'($urandom_range(0, 28'hFFFFFFF));
         dcc  = 28'($urandom_range(0, 28'hFFFFFFF));
         case (p)
            1: inv = 24'hFFFFFF;
            2: inv = 24'd1;
            3: inv = 24'd0;
            4: rows = 9'd0;
            5: begin rows = 9'd400; cols = 9'd511; end
            7: begin scr = 24'hFFFFFF; scc = 24'hFFFFFF; dcr = 28'hFFFFFFF; dcc = 28'hFFFFFFF; end
            8: begin scr = '0; scc = '0; dcr = '0; dcc = '0; end
            9: begin rows = 9'd256; cols = 9'd256; end
            default: ;
         endcase
         csr_write(rsz_pkg::REG_INTERP_MODE, p[0] ? rsz_pkg::MODE_NEAREST : MODE_BILINEAR);
         csr_write(rsz_pkg::REG_INV_SCALE, inv);
         csr_write(rsz_pkg::REG_SRC_ROWS, rows);
         csr_write(rsz_pkg::REG_SRC_COLS, cols);
         csr_write(rsz_pkg::REG_SRC_CENTER_ROW, scr);
         csr_write(rsz_pkg::REG_SRC_CENTER_COL, scc);
         csr_write(rsz_pkg::REG_DST_CENTER_ROW, dcr);
         csr_write(rsz_pkg::REG_DST_CENTER_COL, dcc);

         for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
               send_transaction(load_item(8'(r), 8'(c), 16'($urandom)));
         for (int k = 0; k < 118; k++) begin
            if ($urandom_range(99) < 10) begin
               s = load_item(8'($urandom), 8'($urandom), 16'($urandom));
            end else begin
               tries = 0;
               do begin
                  if ($urandom_range(99) < 75) s = req_item(near_axis(dcr), near_axis(dcc));
                  else s = req_item(12'($urandom), 12'($urandom));
                  tries++;
               end while (!taps_written(s.orow, s.ocol) && tries < 20);
               // fall back to a load when no safe request was found
               if (!taps_written(s.orow, s.ocol))
                  s = load_item(8'($urandom_range(h - 1)), 8'($urandom_range(w - 1)),
                                16'($urandom));
            end
            send_transaction(s);
         end
         req_valid <= 1'b0;
      end

      idle_on = 1'b1;
      wait_drained();
      $display("covered %0d loads, %0d requests, %0d pixels checked over %0d settings",
               n_load, n_req, n_rsp, NUM_PHASES + 1);
      $display("nearest and bilinear modes, scale and centre extremes, empty and oversize images");
      if (errors == 0 && pixel_fifo.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d pixels missing", errors, pixel_fifo.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
